// ===== rtl/cable_robot_step_targets_unit_defines.svh =====
// Assertion macros shared by the step target RTL.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CABLE_ROBOT_STEP_TARGETS_UNIT_DEFINES_SVH
`define CABLE_ROBOT_STEP_TARGETS_UNIT_DEFINES_SVH

// Checks a property on every rising clock edge outside reset.
`define CRST_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks that a condition never holds.
`define CRST_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/crst_pkg.sv =====
// Package for the cable robot step target unit: widths, types and helpers.
// Used by every module of the block; depends on nothing.
`default_nettype none
package crst_pkg;
    localparam int NUM_MOTORS = 4;
    localparam int POS_W = 24;
    localparam int FRAME_W = 24;
    localparam int RATIO_W = 32;
    localparam int MAG_W = 25;
    localparam int SQ_W = 2 * MAG_W;
    localparam int D_W = 52;
    localparam int RAD_W = 62;
    localparam int LEN_W = 31;
    localparam int REM_W = 33;
    localparam int STEP_W = 31;
    localparam int DELTA_W = 32;
    localparam int PROD_W = LEN_W + RATIO_W;
    localparam int PROD_SHIFT = 38;
    localparam int ROOT_STEPS = RAD_W / 2;
    localparam int CNT_W = 5;
    localparam int MOT_W = 2;
    localparam int ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_LENGTH = 2'd1,
        REG_STEP_RATIO   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                      move;
        logic [NUM_MOTORS-1:0][D_W-1:0] dsq;
    } crst_item_t;

    function automatic logic [MAG_W-1:0] crst_mag(input logic signed [MAG_W:0] v);
        logic [MAG_W:0] n;
        n = -v;
        return v[MAG_W] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/crst_front.sv =====
// Front end: takes a position, forms the five squared distance terms and
// the four exact squared cable lengths. Depends on crst_pkg.
`default_nettype none
module crst_front import crst_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      req_type,
    input  wire logic signed [POS_W-1:0]   pos_x_um,
    input  wire logic signed [POS_W-1:0]   pos_y_um,
    input  wire logic signed [POS_W-1:0]   pos_z_um,
    input  wire logic [FRAME_W-1:0]        frame_width_um,
    input  wire logic [FRAME_W-1:0]        frame_length_um,
    output logic                           q_push,
    input  wire logic                      q_full,
    output crst_item_t                     q_item
);
    logic                v1_reg, v2_reg;
    logic                t1_reg, t2_reg;
    logic [MAG_W-1:0]    mag_reg [5];
    logic [SQ_W-1:0]     sq_reg [5];
    logic                ld1, ld2;
    logic signed [MAG_W:0] a_s, b_s, u_s, v_s, w_s;

    assign ld2 = !v2_reg || !q_full;
    assign ld1 = !v1_reg || ld2;
    assign full = !ld1;
    assign q_push = v2_reg && !q_full;

    assign a_s = {2'b00, frame_width_um};
    assign b_s = {2'b00, frame_length_um};
    assign u_s = {pos_x_um[POS_W-1], pos_x_um, 1'b0};
    assign v_s = {pos_y_um[POS_W-1], pos_y_um, 1'b0};
    assign w_s = {pos_z_um[POS_W-1], pos_z_um, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                v1_reg <= push;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            t1_reg <= req_type;
            mag_reg[0] <= crst_mag(a_s - v_s);
            mag_reg[1] <= crst_mag(a_s + v_s);
            mag_reg[2] <= crst_mag(b_s + u_s);
            mag_reg[3] <= crst_mag(b_s - u_s);
            mag_reg[4] <= crst_mag(w_s);
        end
        if (ld2)
        begin
            t2_reg <= t1_reg;
            for (int i = 0; i < 5; i++)
            begin
                sq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
        end
    end

    always_comb
    begin
        q_item.move = t2_reg;
        q_item.dsq[0] = D_W'(sq_reg[0]) + D_W'(sq_reg[2]) + D_W'(sq_reg[4]);
        q_item.dsq[1] = D_W'(sq_reg[0]) + D_W'(sq_reg[3]) + D_W'(sq_reg[4]);
        q_item.dsq[2] = D_W'(sq_reg[1]) + D_W'(sq_reg[2]) + D_W'(sq_reg[4]);
        q_item.dsq[3] = D_W'(sq_reg[1]) + D_W'(sq_reg[3]) + D_W'(sq_reg[4]);
    end
endmodule
`default_nettype wire

// ===== rtl/crst_queue.sv =====
// Two-entry queue of squared lengths between the front and back ends.
// Depends on crst_pkg.
`default_nettype none
module crst_queue import crst_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       wr,
    input  crst_item_t      wr_item,
    output logic            q_full,
    input  wire logic       rd,
    output logic            q_empty,
    output crst_item_t      rd_item
);
    crst_item_t  mem_reg [2];
    logic        wp_reg, rp_reg;
    logic [1:0]  cnt_reg;

    assign q_full = cnt_reg[1];
    assign q_empty = (cnt_reg == 2'd0);
    assign rd_item = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
            begin
                wp_reg <= !wp_reg;
            end
            if (rd)
            begin
                rp_reg <= !rp_reg;
            end
            cnt_reg <= 2'(cnt_reg + {1'b0, wr} - {1'b0, rd});
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem_reg[wp_reg] <= wr_item;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/crst_back.sv =====
// Back end: four square root lanes, a shared step scaling multiplier,
// the current step counts and the result register. Depends on crst_pkg.
`default_nettype none
`include "cable_robot_step_targets_unit_defines.svh"
module crst_back import crst_pkg::*; (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_empty,
    input  crst_item_t                q_item,
    output logic                      q_pop,
    input  wire logic [RATIO_W-1:0]   steps_per_um_q32,
    output logic                      empty,
    input  wire logic                 pop,
    output logic [STEP_W-1:0]         target_steps [NUM_MOTORS],
    output logic [DELTA_W-1:0]        delta_steps [NUM_MOTORS]
);
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROOT  = 4'b0010,
        ST_SCALE = 4'b0100,
        ST_EMIT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                move_reg;
    logic [RAD_W-1:0]    rad_reg [NUM_MOTORS];
    logic [LEN_W-1:0]    root_reg [NUM_MOTORS];
    logic [REM_W-1:0]    rem_reg [NUM_MOTORS];
    logic [RAD_W-1:0]    rad_next [NUM_MOTORS];
    logic [LEN_W-1:0]    root_next [NUM_MOTORS];
    logic [REM_W-1:0]    rem_next [NUM_MOTORS];
    logic [PROD_W-1:0]   prod_reg;
    logic [STEP_W-1:0]   tgt_reg [NUM_MOTORS];
    logic [STEP_W-1:0]   cur_reg [NUM_MOTORS];
    logic                out_valid_reg;
    logic                emit;
    logic [MOT_W-1:0]    mul_idx, wr_idx;

    assign q_pop = (state_reg == ST_IDLE) && !q_empty;
    assign emit = (state_reg == ST_EMIT) && (!out_valid_reg || pop);
    assign empty = !out_valid_reg;
    assign mul_idx = cnt_reg[MOT_W-1:0];
    assign wr_idx = MOT_W'(cnt_reg - CNT_W'(1));

    always_comb
    begin
        logic [REM_W+1:0] r4;
        logic [REM_W+1:0] trial;
        for (int k = 0; k < NUM_MOTORS; k++)
        begin
            r4 = {rem_reg[k], rad_reg[k][RAD_W-1:RAD_W-2]};
            trial = {2'b00, root_reg[k], 2'b01};
            rad_next[k] = {rad_reg[k][RAD_W-3:0], 2'b00};
            if (r4 >= trial)
            begin
                rem_next[k] = REM_W'(r4 - trial);
                root_next[k] = {root_reg[k][LEN_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r4[REM_W-1:0];
                root_next[k] = {root_reg[k][LEN_W-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (!q_empty)
                begin
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT:
            begin
                cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                begin
                    cnt_next = '0;
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                cnt_next = CNT_W'(cnt_reg + CNT_W'(1));
                if (cnt_reg == CNT_W'(NUM_MOTORS))
                begin
                    cnt_next = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                cur_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                for (int k = 0; k < NUM_MOTORS; k++)
                begin
                    cur_reg[k] <= tgt_reg[k];
                end
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            move_reg <= q_item.move;
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                rad_reg[k] <= {q_item.dsq[k], 10'b0};
                root_reg[k] <= '0;
                rem_reg[k] <= '0;
            end
        end
        else if (state_reg == ST_ROOT)
        begin
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                rad_reg[k] <= rad_next[k];
                root_reg[k] <= root_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
        if (state_reg == ST_SCALE)
        begin
            if (cnt_reg < CNT_W'(NUM_MOTORS))
            begin
                prod_reg <= root_reg[mul_idx] * steps_per_um_q32;
            end
            if (cnt_reg != '0)
            begin
                tgt_reg[wr_idx] <= STEP_W'(prod_reg[PROD_W-1:PROD_SHIFT]);
            end
        end
        if (emit)
        begin
            for (int k = 0; k < NUM_MOTORS; k++)
            begin
                target_steps[k] <= tgt_reg[k];
                delta_steps[k] <= move_reg
                    ? DELTA_W'({1'b0, tgt_reg[k]} - {1'b0, cur_reg[k]}) : '0;
            end
        end
    end

    `CRST_ASSERT(a_pop_only_idle, q_pop |-> (state_reg == ST_IDLE), "queue read outside idle")
    `CRST_NEVER(a_root_count, (state_reg == ST_ROOT) && (cnt_reg >= CNT_W'(ROOT_STEPS)), "root count overrun")
    `CRST_ASSERT(a_emit_waits, ((state_reg == ST_EMIT) && out_valid_reg && !pop) |=> (state_reg == ST_EMIT), "result overwritten")
endmodule
`default_nettype wire

// ===== rtl/cable_robot_step_targets_unit.sv =====
// Top level of the cable robot step target unit: register port and wiring.
// Depends on crst_pkg, crst_front, crst_queue and crst_back.
//
// Channel   Handshake            Payload
// input     push / full          req_type, pos_x_um, pos_y_um, pos_z_um
// result    empty / pop          target_steps_m1..m4, delta_steps_m1..m4
// config    psel/penable/pwrite  paddr, pwdata, prdata, pready
//
// The front end takes one position per cycle, unless full is high, into a
// two-stage pipeline. In the back end, 31 square root steps run on four lanes
// in parallel, then the shared step multiplier scales the four roots in turn.
// Reset clears the configuration registers, the current step counts and every
// valid flag; the datapath registers hold no value until a beat loads them.
// Either side may stall; the queue and the result register decouple them.
`default_nettype none
module cable_robot_step_targets_unit import crst_pkg::*; (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic                      req_type,
    input  wire logic signed [POS_W-1:0]   pos_x_um,
    input  wire logic signed [POS_W-1:0]   pos_y_um,
    input  wire logic signed [POS_W-1:0]   pos_z_um,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [STEP_W-1:0]              target_steps_m1,
    output logic [STEP_W-1:0]              target_steps_m2,
    output logic [STEP_W-1:0]              target_steps_m3,
    output logic [STEP_W-1:0]              target_steps_m4,
    output logic signed [DELTA_W-1:0]      delta_steps_m1,
    output logic signed [DELTA_W-1:0]      delta_steps_m2,
    output logic signed [DELTA_W-1:0]      delta_steps_m3,
    output logic signed [DELTA_W-1:0]      delta_steps_m4
);
    logic [FRAME_W-1:0]  width_reg, length_reg;
    logic [RATIO_W-1:0]  ratio_reg;
    logic                wr_en;
    reg_idx_t            idx;
    logic                fq_push, fq_full, bq_empty, bq_pop;
    crst_item_t          fq_item, bq_item;
    logic [STEP_W-1:0]   tgt [NUM_MOTORS];
    logic [DELTA_W-1:0]  dlt [NUM_MOTORS];

    assign pready = 1'b1;
    assign wr_en = psel && penable && pwrite;
    assign idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= '0;
            length_reg <= '0;
            ratio_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_FRAME_WIDTH:  width_reg <= pwdata[FRAME_W-1:0];
                REG_FRAME_LENGTH: length_reg <= pwdata[FRAME_W-1:0];
                REG_STEP_RATIO:   ratio_reg <= pwdata;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_FRAME_WIDTH:  prdata = {8'b0, width_reg};
            REG_FRAME_LENGTH: prdata = {8'b0, length_reg};
            REG_STEP_RATIO:   prdata = ratio_reg;
            default:          prdata = '0;
        endcase
    end

    crst_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .req_type        (req_type),
        .pos_x_um        (pos_x_um),
        .pos_y_um        (pos_y_um),
        .pos_z_um        (pos_z_um),
        .frame_width_um  (width_reg),
        .frame_length_um (length_reg),
        .q_push          (fq_push),
        .q_full          (fq_full),
        .q_item          (fq_item)
    );

    crst_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (fq_push),
        .wr_item (fq_item),
        .q_full  (fq_full),
        .rd      (bq_pop),
        .q_empty (bq_empty),
        .rd_item (bq_item)
    );

    crst_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_empty          (bq_empty),
        .q_item           (bq_item),
        .q_pop            (bq_pop),
        .steps_per_um_q32 (ratio_reg),
        .empty            (empty),
        .pop              (pop),
        .target_steps     (tgt),
        .delta_steps      (dlt)
    );

    assign target_steps_m1 = tgt[0];
    assign target_steps_m2 = tgt[1];
    assign target_steps_m3 = tgt[2];
    assign target_steps_m4 = tgt[3];
    assign delta_steps_m1 = dlt[0];
    assign delta_steps_m2 = dlt[1];
    assign delta_steps_m3 = dlt[2];
    assign delta_steps_m4 = dlt[3];
endmodule
`default_nettype wire

// ===== dv/tb_cable_robot_step_targets_unit.sv =====
// Testbench for the cable robot step target unit: predicts the four step targets and
// deltas for each position beat and checks every result beat against the prediction.
// Depends on crst_pkg and the RTL of cable_robot_step_targets_unit.
`default_nettype none
module tb_cable_robot_step_targets_unit;
    import crst_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic                      req;
        logic signed [POS_W-1:0]   x;
        logic signed [POS_W-1:0]   y;
        logic signed [POS_W-1:0]   z;
    } position_t;

    typedef struct {
        logic [STEP_W-1:0]  tgt [NUM_MOTORS];
        logic [DELTA_W-1:0] dlt [NUM_MOTORS];
    } steps_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic push = 1'b0;
    logic full;
    logic req_type = 1'b0;
    logic signed [POS_W-1:0] pos_x_um = '0, pos_y_um = '0, pos_z_um = '0;
    logic empty;
    logic pop = 1'b0;
    logic [STEP_W-1:0] target_steps_m1, target_steps_m2, target_steps_m3, target_steps_m4;
    logic signed [DELTA_W-1:0] delta_steps_m1, delta_steps_m2, delta_steps_m3, delta_steps_m4;

    cable_robot_step_targets_unit dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [FRAME_W-1:0] frame_a = '0, frame_b = '0;
    logic [RATIO_W-1:0] ratio = '0;
    logic [STEP_W-1:0]  counts [NUM_MOTORS] = '{default: '0};

    position_t pending_positions [$];
    steps_t    expected_steps [$];
    int errors = 0;
    int results_seen = 0;
    int push_gap = 0, pop_gap = 0;

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] n);
        logic [63:0] root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [STEP_W-1:0] cable_steps(input logic [63:0] dsq);
        logic [63:0] len;
        logic [127:0] prod;
        len = int_sqrt(dsq << 10);
        prod = (len * 128'(ratio)) >> 38;
        if (prod > 128'h7FFFFFFF) prod = 128'h7FFFFFFF;
        return prod[STEP_W-1:0];
    endfunction

    function automatic steps_t predict_steps(input position_t p);
        steps_t r;
        longint a, b, u, v, w, ym, yp, xp, xm, zz;
        a = frame_a;
        b = frame_b;
        u = 2 * longint'(p.x);
        v = 2 * longint'(p.y);
        w = 2 * longint'(p.z);
        ym = (a - v) * (a - v);
        yp = (a + v) * (a + v);
        xp = (b + u) * (b + u);
        xm = (b - u) * (b - u);
        zz = w * w;
        r.tgt[0] = cable_steps(ym + xp + zz);
        r.tgt[1] = cable_steps(ym + xm + zz);
        r.tgt[2] = cable_steps(yp + xp + zz);
        r.tgt[3] = cable_steps(yp + xm + zz);
        for (int i = 0; i < NUM_MOTORS; i++)
        begin
            r.dlt[i] = p.req ? (32'(r.tgt[i]) - 32'(counts[i])) : 32'd0;
            counts[i] = r.tgt[i];
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (push && !full)
            expected_steps.push_back(predict_steps('{req_type, pos_x_um, pos_y_um, pos_z_um}));
        if (push && full)
            ;
        else if (push_gap > 0)
        begin
            push <= 1'b0;
            push_gap <= push_gap - 1;
        end
        else if (pending_positions.size() > 0)
        begin
            position_t p;
            p = pending_positions.pop_front();
            push <= 1'b1;
            req_type <= p.req;
            pos_x_um <= p.x;
            pos_y_um <= p.y;
            pos_z_um <= p.z;
            push_gap <= rand_gap();
        end
        else
            push <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (pop && !empty)
        begin
            logic [STEP_W-1:0]  got_t [NUM_MOTORS];
            logic [DELTA_W-1:0] got_d [NUM_MOTORS];
            steps_t e;
            got_t = '{target_steps_m1, target_steps_m2, target_steps_m3, target_steps_m4};
            got_d = '{delta_steps_m1, delta_steps_m2, delta_steps_m3, delta_steps_m4};
            results_seen++;
            if (expected_steps.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat");
            end
            else
            begin
                e = expected_steps.pop_front();
                for (int i = 0; i < NUM_MOTORS; i++)
                begin
                    if (got_t[i] !== e.tgt[i] || got_d[i] !== e.dlt[i])
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("Motor %0d: expected target %0d delta %0d, got %0d %0d",
                                     i + 1, e.tgt[i], $signed(e.dlt[i]), got_t[i],
                                     $signed(got_d[i]));
                    end
                end
            end
        end
        if (pop_gap > 0)
        begin
            pop <= 1'b0;
            pop_gap <= pop_gap - 1;
        end
        else
        begin
            pop <= 1'b1;
            if (pop && !empty) pop_gap <= rand_gap();
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_FRAME_WIDTH:  frame_a = val[FRAME_W-1:0];
            REG_FRAME_LENGTH: frame_b = val[FRAME_W-1:0];
            default:          ratio = val;
        endcase
    endtask

    task automatic configure(input logic [31:0] a, input logic [31:0] b, input logic [31:0] r);
        reg_write(REG_FRAME_WIDTH, a);
        reg_write(REG_FRAME_LENGTH, b);
        reg_write(REG_STEP_RATIO, r);
    endtask

    task automatic drain();
        while (pending_positions.size() > 0 || push || expected_steps.size() > 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic logic signed [POS_W-1:0] rand_pos(input int span);
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return POS_W'($urandom);
        if (r == 1) return ($urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000);
        return POS_W'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic random_phase(input int n, input int span);
        position_t p;
        for (int i = 0; i < n; i++)
        begin
            p.req = ($urandom_range(0, 9) != 0);
            p.x = rand_pos(span);
            p.y = rand_pos(span);
            p.z = rand_pos(span);
            pending_positions.push_back(p);
        end
        drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        configure(32'd0, 32'd0, 32'd0);
        pending_positions.push_back('{1'b1, 24'sd1000, -24'sd2000, 24'sd3000});
        drain();

        configure(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFFFF);
        pending_positions.push_back('{1'b0, 24'sd0, 24'sd0, 24'sd0});
        pending_positions.push_back('{1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF});
        pending_positions.push_back('{1'b1, -24'sh800000, -24'sh800000, -24'sh800000});
        pending_positions.push_back('{1'b1, 24'sh7FFFFF, -24'sh800000, 24'sd0});
        pending_positions.push_back('{1'b1, -24'sh800000, 24'sh7FFFFF, -24'sh800000});
        pending_positions.push_back('{1'b1, 24'sd0, 24'sd0, 24'sd0});
        pending_positions.push_back('{1'b0, 24'sd5, -24'sd5, 24'sd1});
        pending_positions.push_back('{1'b1, 24'sd5, -24'sd5, 24'sd1});
        drain();

        configure(32'd2000000, 32'd3000000, 32'h0000_0001);
        pending_positions.push_back('{1'b1, 24'sd1, 24'sd1, 24'sd1});
        pending_positions.push_back('{1'b1, -24'sd1, -24'sd1, -24'sd1});
        drain();

        configure(32'd4000000, 32'd6000000, 32'h3000_0000);
        random_phase(600, 3000000);
        configure($urandom, $urandom, $urandom);
        random_phase(500, 8388607);
        configure(32'hFFFFFF, 32'd0, 32'hFFFFFFFF);
        random_phase(400, 1000);
        configure(32'd100, 32'd200, $urandom);
        random_phase(350, 8388607);

        $display("Ran %0d result beats over several frame and ratio settings with random stalls.",
                 results_seen);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire
